[hw/rtl/pli_pkg.sv]
// Package for the piecewise linear interpolator.
// Holds the shared item type, table sizes and configuration register indexes.
// No dependencies.
package pli_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IndexWidth = 6;
  localparam int unsigned CountWidth = 7;
  localparam int unsigned ValueWidth = 32;

  // Configuration register indexes.
  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_ERROR_VALUE = 1'b1;

  // Item mode codes.
  localparam logic MODE_QUERY = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic                  mode;
    logic [IndexWidth-1:0] index;
    logic [ValueWidth-1:0] val_a;  // point_x for a write, query_x for a query
    logic [ValueWidth-1:0] val_b;  // point_y for a write
  } item_t;

  // Queue to back end handshake.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

[hw/rtl/pli_front.sv]
// Front end of the interpolator: accepts input transactions, classifies them
// and holds them in a two-entry queue. Depends on pli_pkg.
module pli_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         in_mode_i,
  input  logic [pli_pkg::IndexWidth-1:0] in_index_i,
  input  logic [pli_pkg::ValueWidth-1:0] in_point_x_i,
  input  logic [pli_pkg::ValueWidth-1:0] in_point_y_i,
  input  logic [pli_pkg::ValueWidth-1:0] in_query_x_i,
  output pli_pkg::queue_out_t          queue_o,
  input  logic                         pop_i
);

  pli_pkg::item_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           push;
  logic           pop;
  pli_pkg::item_t new_item;

  // Classify: a query carries its x in val_a, a write carries the point.
  always_comb begin
    new_item.mode  = in_mode_i;
    new_item.index = in_index_i;
    new_item.val_a = (in_mode_i == pli_pkg::MODE_WRITE) ? in_point_x_i : in_query_x_i;
    new_item.val_b = in_point_y_i;
  end

  assign in_ready_o = (fill_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (fill_q != 2'd0);

  assign queue_o.valid = (fill_q != 2'd0);
  assign queue_o.item  = entry_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

[hw/rtl/pli_back.sv]
// Back end of the interpolator: breakpoint tables, sequential search,
// multiply, serial divide and the output register. Depends on pli_pkg.
module pli_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pli_pkg::queue_out_t            queue_i,
  output logic                           pop_o,
  input  logic [pli_pkg::CountWidth-1:0] point_count_i,
  input  logic [pli_pkg::ValueWidth-1:0] error_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pli_pkg::ValueWidth-1:0] out_result_o,
  output logic                           out_flag_o
);

  localparam int unsigned VW = pli_pkg::ValueWidth;
  localparam int unsigned IW = pli_pkg::IndexWidth;
  localparam int unsigned CW = pli_pkg::CountWidth;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_RD1  = 7'b0000100,
    S_RD2  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [VW-1:0] mem_x [pli_pkg::TableDepth];
  logic [VW-1:0] mem_y [pli_pkg::TableDepth];
  logic [IW-1:0] raddr_x, raddr_y;
  logic [VW-1:0] rd_x_q, rd_y_q;
  logic          mem_we;

  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   addr_q, addr_d;
  logic [IW-1:0]   cu_q, cu_d;
  logic            cv_q, cv_d;
  logic [IW-1:0]   u_q, u_d;
  logic [VW-1:0]   qx_q, qx_d;
  logic [VW-1:0]   x1_q, x1_d;
  logic [VW-1:0]   y1_q, y1_d;
  logic [VW-1:0]   x0_q, x0_d;
  logic [VW-1:0]   y0_q, y0_d;
  logic [VW-1:0]   dx_q, dx_d;
  logic            neg_q, neg_d;
  logic [2*VW-1:0] prod_q, prod_d;
  logic [4:0]      step_q, step_d;
  logic [VW-1:0]   res_q, res_d;
  logic            oor_q, oor_d;
  logic            ovalid_q, ovalid_d;
  logic [VW-1:0]   ores_q, ores_d;
  logic            oflag_q, oflag_d;

  logic [VW-1:0] fx, dy;
  logic [VW:0]   trial;
  logic          hit;
  logic          out_free;

  assign out_free     = !ovalid_q || out_ready_i;
  assign out_valid_o  = ovalid_q;
  assign out_result_o = ores_q;
  assign out_flag_o   = oflag_q;

  // Table memories: one write and one registered read port each.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[queue_i.item.index] <= queue_i.item.val_a;
      mem_y[queue_i.item.index] <= queue_i.item.val_b;
    end
    rd_x_q <= mem_x[raddr_x];
    rd_y_q <= mem_y[raddr_y];
  end

  assign hit   = cv_q && ($signed(qx_q) < $signed(rd_x_q));
  assign fx    = qx_q - x0_q;
  assign dy    = ($signed(y1_q) >= $signed(rd_y_q)) ? (y1_q - rd_y_q) : (rd_y_q - y1_q);
  assign trial = {prod_q[2*VW-1:VW], prod_q[VW-1]} - {1'b0, dx_q};

  // Sequencer for search, fetch, multiply, divide and result hand-off.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    addr_d   = addr_q;
    cu_d     = cu_q;
    cv_d     = 1'b0;
    u_d      = u_q;
    qx_d     = qx_q;
    x1_d     = x1_q;
    y1_d     = y1_q;
    x0_d     = x0_q;
    y0_d     = y0_q;
    dx_d     = dx_q;
    neg_d    = neg_q;
    prod_d   = prod_q;
    step_d   = step_q;
    res_d    = res_q;
    oor_d    = oor_q;
    ovalid_d = out_ready_i ? 1'b0 : ovalid_q;
    ores_d   = ores_q;
    oflag_d  = oflag_q;
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    raddr_x  = addr_q[IW-1:0];
    raddr_y  = u_q;

    unique case (state_q)
      S_IDLE: begin
        if (queue_i.valid) begin
          pop_o = 1'b1;
          if (queue_i.item.mode == pli_pkg::MODE_WRITE) begin
            mem_we = 1'b1;
          end else begin
            qx_d    = queue_i.item.val_a;
            count_d = (point_count_i > CW'(pli_pkg::TableDepth)) ?
                      CW'(pli_pkg::TableDepth) : point_count_i;
            addr_d  = '0;
            res_d   = error_value_i;
            oor_d   = 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // One entry issued per cycle; its compare follows in the next cycle.
        if (hit) begin
          if (cu_q == '0) begin
            state_d = S_OUT;
          end else begin
            x1_d    = rd_x_q;
            u_d     = cu_q;
            state_d = S_RD1;
          end
        end else if (addr_q < count_q) begin
          cu_d   = addr_q[IW-1:0];
          cv_d   = 1'b1;
          addr_d = addr_q + 1'b1;
        end else begin
          state_d = S_OUT;
        end
      end
      S_RD1: begin
        raddr_x = u_q - 1'b1;
        raddr_y = u_q;
        state_d = S_RD2;
      end
      S_RD2: begin
        raddr_y = u_q - 1'b1;
        x0_d    = rd_x_q;
        y1_d    = rd_y_q;
        state_d = S_MUL;
      end
      S_MUL: begin
        y0_d    = rd_y_q;
        dx_d    = x1_q - x0_q;
        neg_d   = $signed(y1_q) < $signed(rd_y_q);
        prod_d  = {{VW{1'b0}}, fx} * {{VW{1'b0}}, dy};
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        // Restoring divide, one quotient bit per cycle into the low half.
        if (!trial[VW]) begin
          prod_d = {trial[VW-1:0], prod_q[VW-2:0], 1'b1};
        end else begin
          prod_d = {prod_q[2*VW-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == 5'd31) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          oflag_d  = oor_q;
          if (oor_q) begin
            ores_d = res_q;
          end else if (neg_q) begin
            ores_d = y0_q - prod_q[VW-1:0];
          end else begin
            ores_d = y0_q + prod_q[VW-1:0];
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A found pair clears the out-of-range mark.
    if (state_q == S_SCAN && hit && cu_q != '0) begin
      oor_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cv_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cv_q     <= cv_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    addr_q  <= addr_d;
    cu_q    <= cu_d;
    u_q     <= u_d;
    qx_q    <= qx_d;
    x1_q    <= x1_d;
    y1_q    <= y1_d;
    x0_q    <= x0_d;
    y0_q    <= y0_d;
    dx_q    <= dx_d;
    neg_q   <= neg_d;
    prod_q  <= prod_d;
    step_q  <= step_d;
    res_q   <= res_d;
    oor_q   <= oor_d;
    ores_q  <= ores_d;
    oflag_q <= oflag_d;
  end

endmodule

[hw/rtl/piecewise_linear_interpolator.sv]
// Piecewise linear interpolator over a table of up to 64 Q16.16 breakpoints.
// A write transaction (tuser = 1) stores one breakpoint and gives no
// result; a query (tuser = 0) returns one result. An accepted transaction
// is registered in the queue before it reaches the back end. A query is
// dequeued, searched for its pair, has its pair fetched and multiplied, goes
// through the one-bit-per-cycle divider and then loads the result; the serial
// divider and the sequential table search through a single memory read port
// set the time a query takes. A miss goes from the search straight to the result.
// A stalled result holds the next result's hand-off in the back end until it
// is taken. A two-entry queue lets input transactions arrive while the back
// end is busy. Depends on pli_pkg, pli_front and pli_back.
module piecewise_linear_interpolator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // point_index[5:0], point_x, point_y, query_x, pad
  input  logic         s_axis_tuser,   // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // result_y
  output logic         m_axis_tuser,   // out_of_range
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [pli_pkg::CountWidth-1:0] point_count_q;
  logic [pli_pkg::ValueWidth-1:0] error_value_q;
  pli_pkg::queue_out_t            queue;
  logic                           pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
      error_value_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pli_pkg::CFG_POINT_COUNT: point_count_q <= cfg_data_i[pli_pkg::CountWidth-1:0];
        pli_pkg::CFG_ERROR_VALUE: error_value_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pli_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_mode_i    (s_axis_tuser),
    .in_index_i   (s_axis_tdata[5:0]),
    .in_point_x_i (s_axis_tdata[37:6]),
    .in_point_y_i (s_axis_tdata[69:38]),
    .in_query_x_i (s_axis_tdata[101:70]),
    .queue_o      (queue),
    .pop_i        (pop)
  );

  pli_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_i       (queue),
    .pop_o         (pop),
    .point_count_i (point_count_q),
    .error_value_i (error_value_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_result_o  (m_axis_tdata),
    .out_flag_o    (m_axis_tuser)
  );

endmodule

[hw/rtl/pli_checker.sv]
// Port-level checker for the piecewise linear interpolator, with its bind.
// Depends on pli_pkg and the top level's ports.
module pli_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        cfg_we_i,
  input logic        cfg_index_i,
  input logic [31:0] cfg_data_i
);

  logic [31:0] err_q;

  // Shadow copy of the error value register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= '0;
    end else if (cfg_we_i && cfg_index_i == pli_pkg::CFG_ERROR_VALUE) begin
      err_q <= cfg_data_i;
    end
  end

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // No result is offered during reset.
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // An out-of-range result carries the configured error value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == err_q)
    else $error("out-of-range result differs from error value");

endmodule

bind piecewise_linear_interpolator pli_port_checker u_pli_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_we_i      (cfg_we_i),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i)
);

[sim/pli_checker.sv]
// Checker for the piecewise linear interpolator: watches the input, output and
// configuration channels, predicts each result from its own table and compares.
// Depends on pli_pkg.
module pli_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [31:0]  m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic [31:0] y;
    logic        oor;
  } lookup_t;

  logic signed [31:0] bp_x [pli_pkg::TableDepth];
  logic signed [31:0] bp_y [pli_pkg::TableDepth];
  logic [6:0]         count_q;
  logic signed [31:0] err_val_q;
  lookup_t            expected_q [$];

  assign pending_o = expected_q.size();

  // Exact interpolation with unsigned 64-bit products; the result lies between y0 and y1.
  function automatic lookup_t interpolate(logic signed [31:0] qx);
    lookup_t          r;
    int               n;
    longint           dx, fx, dy;
    longint unsigned  udx, ufx, ady, num, quo;
    r.y   = err_val_q;
    r.oor = 1'b1;
    n     = int'((count_q > pli_pkg::TableDepth) ? pli_pkg::TableDepth : count_q);
    for (int u = 0; u < n; u++) begin
      if (qx < bp_x[u]) begin
        if (u != 0) begin
          dx  = longint'(bp_x[u]) - longint'(bp_x[u-1]);
          fx  = longint'(qx) - longint'(bp_x[u-1]);
          dy  = longint'(bp_y[u]) - longint'(bp_y[u-1]);
          udx = dx;
          ufx = fx;
          ady = (dy < 0) ? -dy : dy;
          num = ufx * ady;
          quo = num / udx;
          r.y   = 32'(longint'(bp_y[u-1]) + ((dy < 0) ? -longint'(quo) : longint'(quo)));
          r.oor = 1'b0;
        end
        break;
      end
    end
    return r;
  endfunction

  task automatic report(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  // Track configuration, table writes, queries and results on each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      err_val_q    <= '0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == pli_pkg::CFG_POINT_COUNT) count_q <= cfg_data_i[6:0];
        else err_val_q <= cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == pli_pkg::MODE_WRITE) begin
          bp_x[s_axis_tdata[5:0]] = s_axis_tdata[37:6];
          bp_y[s_axis_tdata[5:0]] = s_axis_tdata[69:38];
        end else begin
          expected_q.push_back(interpolate(s_axis_tdata[101:70]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result y=%h oor=%b", m_axis_tdata, m_axis_tuser));
        end else begin
          lookup_t e;
          e = expected_q.pop_front();
          if (m_axis_tdata !== e.y)
            report($sformatf("result_y %h, expected %h", m_axis_tdata, e.y));
          if (m_axis_tuser !== e.oor)
            report($sformatf("out_of_range %b, expected %b", m_axis_tuser, e.oor));
        end
      end
    end
  end

endmodule

[sim/tb_piecewise_linear_interpolator.sv]
// Testbench top for the piecewise linear interpolator: clock, reset, stimulus
// and verdict. Depends on pli_pkg, pli_checker and the interpolator RTL.
module tb_piecewise_linear_interpolator;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;   // point_index, point_x, point_y, query_x, pad
  logic         s_axis_tuser = pli_pkg::MODE_QUERY;  // mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;        // result_y
  logic         m_axis_tuser;        // out_of_range
  logic         cfg_we_i = 1'b0;
  logic         cfg_index_i = pli_pkg::CFG_POINT_COUNT;
  logic [31:0]  cfg_data_i = '0;
  int           fail_count;
  int           pending;
  logic         stall_en = 1'b0;
  logic signed [31:0] grid_x [pli_pkg::TableDepth];

  always #6 clk_i = ~clk_i;

  piecewise_linear_interpolator i_dut (.*);

  pli_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stall pattern: always ready when disabled, random stalls when enabled.
  always @(posedge clk_i) begin
    m_axis_tready <= stall_en ? ($urandom_range(0, 9) < 6) : 1'b1;
  end

  // Send one transaction; a finished burst drops valid for a random gap.
  int burst_left = 0;
  task automatic send(logic mode, logic [5:0] idx, logic [31:0] px, logic [31:0] py,
                      logic [31:0] qx);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {2'b00, qx, py, px, idx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_pt(logic [5:0] idx, logic [31:0] px, logic [31:0] py);
    send(pli_pkg::MODE_WRITE, idx, px, py, $urandom());
  endtask

  task automatic query(logic [31:0] qx);
    send(pli_pkg::MODE_QUERY, 6'($urandom()), $urandom(), $urandom(), qx);
  endtask

  // Wait until every result has arrived and the back end has gone quiet.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic set_reg(logic idx, logic [31:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Fill all slots with an ascending table spread over the given x range.
  task automatic load_table(logic signed [31:0] lo, int step, bit extreme_y);
    logic signed [31:0] y;
    for (int i = 0; i < pli_pkg::TableDepth; i++) begin
      grid_x[i] = lo + i * step + $urandom_range(0, step / 2);
      case ($urandom_range(0, 3))
        0: y = extreme_y ? 32'sh7fffffff : $urandom();
        1: y = extreme_y ? 32'sh80000000 : $urandom();
        default: y = $urandom();
      endcase
      write_pt(6'(i), grid_x[i], y);
    end
  endtask

  function automatic logic [31:0] pick_query(int n);
    int k;
    k = $urandom_range(0, n);
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return grid_x[(k < n) ? k : n - 1];
      2: return grid_x[0] - 1;
      default: return grid_x[(k < n - 1) ? k : 0] + $urandom_range(0, 4000);
    endcase
  endfunction

  initial begin
    int counts [6] = '{64, 2, 1, 127, 17, 40};
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: count zero, extreme values, two-point table, write index bits.
    query(32'h0000_0000);
    drain();
    set_reg(pli_pkg::CFG_ERROR_VALUE, 32'h8000_0000);
    query(32'h7fff_ffff);
    drain();
    write_pt(6'd0, 32'sh80000000, 32'sh7fffffff);
    write_pt(6'd1, 32'sh7fffffff, 32'sh80000000);
    drain();
    set_reg(pli_pkg::CFG_POINT_COUNT, 32'd2);
    set_reg(pli_pkg::CFG_ERROR_VALUE, 32'h7fff_ffff);
    query(32'h8000_0000);
    query(32'h7fff_fffe);
    query(32'h7fff_ffff);
    query(32'h0000_0000);
    query(32'hffff_ffff);
    write_pt(6'd63, 32'h1234_5678, 32'hedcb_a987);
    write_pt(6'd42, 32'h0, 32'h0);
    query(32'h0001_0000);
    drain();

    // Random phases over several table shapes and register settings.
    stall_en = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      int n;
      load_table(ph[0] ? 32'sh80000000 : -32'sd4000000, ph[0] ? 67000000 : 120000, ph[1]);
      drain();
      set_reg(pli_pkg::CFG_POINT_COUNT, counts[ph]);
      set_reg(pli_pkg::CFG_ERROR_VALUE, $urandom());
      n = (counts[ph] > pli_pkg::TableDepth) ? pli_pkg::TableDepth : counts[ph];
      stall_en = (ph != 2);
      for (int k = 0; k < 27; k++) begin
        if ($urandom_range(0, 9) == 0)
          write_pt(6'($urandom_range(0, n - 1) == n - 1 ? n - 1 : $urandom_range(n, 63)),
                   $urandom(), $urandom());
        else
          query(pick_query(n));
      end
      drain();
    end

    drain();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #12000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
